/* rtl/frha_pkg.sv */
`timescale 1ns / 1ps

package frha_pkg;

  // Pool geometry: handles and counts have fixed widths on the ports
  localparam int unsigned PoolSize = 256;
  localparam int unsigned HandleW  = 8;
  localparam int unsigned CountW   = 9;

  typedef logic [HandleW-1:0] handle_t;
  typedef logic [CountW-1:0]  count_t;

  // Request kinds
  typedef enum logic [1:0] {
    KindAlloc   = 2'd0,
    KindTry     = 2'd1,
    KindRelease = 2'd2,
    KindUnused  = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StNone      = 2'd1,
    StInvalid   = 2'd2,
    StExhausted = 2'd3
  } status_e;

  // Control sequencer
  typedef enum logic {
    StateIdle = 1'b0,
    StateExec = 1'b1
  } state_e;

endpackage

/* rtl/fifo_reuse_handle_allocator.sv */
`timescale 1ns / 1ps

// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+---------------------------------------
// in      | input     | in_valid_i / in_stall_o   | kind_i, handle_in_i
// out     | output    | out_valid_o / out_stall_i | handle_out_o, status_o,
//         |           |                           | allocated_count_o, released_count_o
//
// The idle state takes an item and reads the head slot of the reuse queue and the held
// flag of the handle in; the execute state updates queue, bitmap, counters and the
// result register. The next item is taken while a finished result still waits.
// Reset clears all control state; neither memory needs clearing, as a held flag
// counts only for handles below the never-used counter.
// A stalled output holds the item in its execute cycle until the result register frees.

module fifo_reuse_handle_allocator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               kind_i,
  input  logic [7:0]               handle_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               handle_out_o,
  output logic [1:0]               status_o,
  output logic [8:0]               allocated_count_o,
  output logic [8:0]               released_count_o
);

  frha_pkg::state_e  state_q, state_d;

  // Accepted request
  frha_pkg::kind_e   kind_q;
  frha_pkg::handle_t hin_q;

  // Queue and pool bookkeeping
  frha_pkg::handle_t head_q, head_d;
  frha_pkg::handle_t tail_q, tail_d;
  frha_pkg::count_t  fill_q, fill_d;
  frha_pkg::count_t  fresh_q, fresh_d;
  frha_pkg::count_t  total_q, total_d;

  // Reuse queue memory
  frha_pkg::handle_t queue_mem [frha_pkg::PoolSize];
  frha_pkg::handle_t rdata_q;

  // Held bitmap memory; an entry is only meaningful below the never-used counter
  logic              held_mem [frha_pkg::PoolSize];
  logic              held_rd_q;
  logic              held_ok;

  // Result register
  logic              out_valid_q;
  frha_pkg::handle_t out_handle_q, hout;
  frha_pkg::status_e out_status_q, status;
  frha_pkg::count_t  out_alloc_q, out_rel_q;

  logic              in_fire, exec_fire;
  logic              held_set, held_clr, mem_we;
  frha_pkg::handle_t held_idx;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign exec_fire = (state_q == frha_pkg::StateExec) && (!out_valid_q || !out_stall_i);

  // Handle in is held only if it was ever handed out and its flag is still set
  assign held_ok   = (frha_pkg::count_t'(hin_q) < fresh_q) && held_rd_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      frha_pkg::StateIdle: if (in_fire) state_d = frha_pkg::StateExec;
      frha_pkg::StateExec: if (exec_fire) state_d = frha_pkg::StateIdle;
      default:             state_d = frha_pkg::StateIdle;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = (state_q != frha_pkg::StateIdle);
  end

  // Request evaluation against the head slot read when the request was accepted
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    fresh_d  = fresh_q;
    total_d  = total_q;
    hout     = '0;
    status   = frha_pkg::StOk;
    held_set = 1'b0;
    held_clr = 1'b0;
    held_idx = hin_q;
    mem_we   = 1'b0;
    case (kind_q)
      frha_pkg::KindAlloc, frha_pkg::KindTry: begin
        if (fill_q != '0) begin
          // reuse the oldest released handle
          hout     = rdata_q;
          held_idx = rdata_q;
          held_set = 1'b1;
          head_d   = head_q + 1'b1;
          fill_d   = fill_q - 1'b1;
          total_d  = total_q + 1'b1;
        end else if (kind_q == frha_pkg::KindTry) begin
          status = frha_pkg::StNone;
        end else if (fresh_q < frha_pkg::count_t'(frha_pkg::PoolSize)) begin
          // hand out a never-used handle
          hout     = fresh_q[frha_pkg::HandleW-1:0];
          held_idx = fresh_q[frha_pkg::HandleW-1:0];
          held_set = 1'b1;
          fresh_d  = fresh_q + 1'b1;
          total_d  = total_q + 1'b1;
        end else begin
          status = frha_pkg::StExhausted;
        end
      end
      frha_pkg::KindRelease: begin
        if (!held_ok || fill_q == frha_pkg::count_t'(frha_pkg::PoolSize)) begin
          status = frha_pkg::StInvalid;
        end else begin
          held_clr = 1'b1;
          mem_we   = 1'b1;
          tail_d   = tail_q + 1'b1;
          fill_d   = fill_q + 1'b1;
          total_d  = total_q - 1'b1;
        end
      end
      default: status = frha_pkg::StInvalid;
    endcase
  end

  // Queue memory: one write at the tail, one registered read at the head
  always_ff @(posedge clk_i) begin
    if (exec_fire && mem_we) queue_mem[tail_q] <= hin_q;
    if (in_fire) rdata_q <= queue_mem[head_q];
  end

  // Held bitmap: at most one write per executed item, one registered read at the handle in
  always_ff @(posedge clk_i) begin
    if (exec_fire && (held_set || held_clr)) held_mem[held_idx] <= held_set;
    if (in_fire) held_rd_q <= held_mem[handle_in_i];
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= frha_pkg::kind_e'(kind_i);
      hin_q  <= handle_in_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frha_pkg::StateIdle;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      fresh_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        fill_q      <= fill_d;
        fresh_q     <= fresh_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_handle_q <= hout;
      out_status_q <= status;
      out_alloc_q  <= total_d;
      out_rel_q    <= fill_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign handle_out_o      = out_handle_q;
  assign status_o          = out_status_q;
  assign allocated_count_o = out_alloc_q;
  assign released_count_o  = out_rel_q;

endmodule
